>>> hw/rtl/sobel_pkg.sv
// Shared types, constants and register codes for the Sobel edge threshold unit.
package sobel_pkg;

  localparam int PIXEL_BITS     = 8;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int CFG_BITS    = 12;
  localparam int IDX_BITS    = 2;
  localparam int THRESH_BITS = 8;

  localparam logic [CFG_BITS-1:0]    WIDTH_RST  = 12'd640;
  localparam logic [CFG_BITS-1:0]    HEIGHT_RST = 12'd480;
  localparam logic [THRESH_BITS-1:0] THRESH_RST = 8'd150;

  // Gradient and magnitude widths: |g| <= 4*255, g*g < 2^20, sum of two < 2^21.
  localparam int GRAD_BITS = 12;
  localparam int SQ_BITS   = 21;
  localparam int MAG_BITS  = 22;

  localparam int FIFO_DEPTH = 4;

  localparam logic [PIXEL_BITS-1:0] EDGE_ON  = 8'hFF;
  localparam logic [PIXEL_BITS-1:0] EDGE_OFF = 8'h00;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_PAD   = 1'b1;

  typedef enum logic [IDX_BITS-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Masked 3x3 neighborhood; the center pixel takes no part in either sum.
  typedef struct packed {
    logic [PIXEL_BITS-1:0] tl;
    logic [PIXEL_BITS-1:0] tc;
    logic [PIXEL_BITS-1:0] tr;
    logic [PIXEL_BITS-1:0] ml;
    logic [PIXEL_BITS-1:0] mr;
    logic [PIXEL_BITS-1:0] bl;
    logic [PIXEL_BITS-1:0] bc;
    logic [PIXEL_BITS-1:0] br;
    logic                  last;
  } window_t;

  typedef struct packed {
    logic    valid;
    window_t win;
  } push_t;

endpackage

>>> hw/rtl/sobel_edge_threshold_3x3_unit.sv
// Top level of the streaming 3x3 Sobel edge detector with binary threshold.
// Pixels enter in raster order, one beat per clock; while no stall holds it, the unit
// sustains one beat per cycle on both sides. Each result is 255 when gv^2+gh^2 reaches
// (edge_threshold+1)^2 and 0 otherwise, with neighbors outside the image taken
// as zero. A result belongs to the pixel one row plus one pixel behind the
// beat that produces it, so after the last pixel of a frame the source sends
// image_width+1 pad beats (command = 1) to drain it; frame_last marks the
// final result of the frame and counters then restart. The result path is
// registered in order: the front end registers the line-buffer read at
// acceptance, the masked window is then written into the four-entry queue,
// and the back end adds three more registers (sums, squares, compare).
// The queue lets the back end stall on result_stall without blocking input
// until it fills. Input stalls in the cycle of each configuration write and
// the cycle after, and in the first cycle out of reset, while the clamped
// sizes and pixel count settle.
// Widths of 0 act as 1, sizes above MAX_WIDTH / MAX_HEIGHT act as the maximum.
module sobel_edge_threshold_3x3_unit #(
  parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input beats
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic                             command,
  input  logic [sobel_pkg::PIXEL_BITS-1:0] pixel_value,
  // result beats
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [sobel_pkg::PIXEL_BITS-1:0] edge_value,
  output logic                             frame_last,
  // configuration writes
  input  logic                             cfg_write,
  input  logic [sobel_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [sobel_pkg::CFG_BITS-1:0]   cfg_data
);

  localparam int WB       = $clog2(MAX_WIDTH + 1);
  localparam int HB       = $clog2(MAX_HEIGHT + 1);
  localparam int TB       = WB + HB;
  localparam int LVL_BITS = $clog2(sobel_pkg::FIFO_DEPTH + 1);

  logic [sobel_pkg::CFG_BITS-1:0]    image_width, image_height;
  logic [sobel_pkg::THRESH_BITS-1:0] edge_threshold;
  logic [WB-1:0]                     width_comb, width_c;
  logic [HB-1:0]                     height_comb, height_c;
  logic [TB-1:0]                     total_m1;
  logic                              cfg_hold, cfg_busy;

  sobel_pkg::push_t   push;
  sobel_pkg::window_t head;
  logic               head_valid, pop;
  logic [LVL_BITS-1:0] queue_level;

  // Register file: write only, decoded by index; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= sobel_pkg::WIDTH_RST;
      image_height   <= sobel_pkg::HEIGHT_RST;
      edge_threshold <= sobel_pkg::THRESH_RST;
    end else if (cfg_write) begin
      case (sobel_pkg::cfg_reg_t'(cfg_index))
        sobel_pkg::REG_IMAGE_WIDTH:    image_width    <= cfg_data;
        sobel_pkg::REG_IMAGE_HEIGHT:   image_height   <= cfg_data;
        sobel_pkg::REG_EDGE_THRESHOLD: edge_threshold <= cfg_data[sobel_pkg::THRESH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes into 1..MAX and form the pixel count minus one.
  always_comb begin
    if (image_width == '0) begin
      width_comb = WB'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      width_comb = WB'(MAX_WIDTH);
    end else begin
      width_comb = WB'(image_width);
    end
    if (image_height == '0) begin
      height_comb = HB'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      height_comb = HB'(MAX_HEIGHT);
    end else begin
      height_comb = HB'(image_height);
    end
  end

  always_ff @(posedge clk) begin
    width_c  <= width_comb;
    height_c <= height_comb;
    total_m1 <= TB'(width_comb) * TB'(height_comb) - TB'(1);
  end

  // Hold input for the write cycle and the one after, and for the first cycle
  // out of reset, while the above settles.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_hold <= 1'b1;
    end else begin
      cfg_hold <= cfg_write;
    end
  end

  assign cfg_busy = cfg_write | cfg_hold;

  sobel_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .command     (command),
    .pixel_value (pixel_value),
    .width_c     (width_c),
    .height_c    (height_c),
    .total_m1    (total_m1),
    .cfg_busy    (cfg_busy),
    .queue_level (queue_level),
    .push        (push)
  );

  sobel_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .level      (queue_level)
  );

  sobel_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .edge_threshold (edge_threshold),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .edge_value     (edge_value),
    .frame_last     (frame_last)
  );

endmodule

>>> hw/rtl/sobel_front.sv
// Front end: raster counters, line buffers, 3x3 window and edge masks.
module sobel_front #(
  parameter int  MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
  parameter int  MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF,
  localparam int WB        = $clog2(MAX_WIDTH + 1),
  localparam int HB        = $clog2(MAX_HEIGHT + 1),
  localparam int TB        = WB + HB,
  localparam int LVL_BITS  = $clog2(sobel_pkg::FIFO_DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic                             command,
  input  logic [sobel_pkg::PIXEL_BITS-1:0] pixel_value,
  input  logic [WB-1:0]                    width_c,
  input  logic [HB-1:0]                    height_c,
  input  logic [TB-1:0]                    total_m1,
  input  logic                             cfg_busy,
  input  logic [LVL_BITS-1:0]              queue_level,
  output sobel_pkg::push_t                 push
);

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT) + 1;
  localparam int EMIT_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int PB        = sobel_pkg::PIXEL_BITS;

  logic [COL_BITS-1:0]  column_count, column_count_next, x, ex;
  logic [ROW_BITS-1:0]  row_count, row_count_next, y, ey;
  logic [EMIT_BITS-1:0] emitted_count, emitted_count_next;
  logic [COL_BITS:0]    x_inc;
  logic                 accept, wrap0, emit, last, top, bot, lft, rgt;

  logic [PB-1:0] upper_line [MAX_WIDTH];
  logic [PB-1:0] middle_line [MAX_WIDTH];
  logic [PB-1:0] upper_rd, middle_rd, upper_eff, middle_eff;
  logic          byp_hit;
  logic [PB-1:0] byp_upper, byp_middle;

  logic                b_valid, b_emit, b_last, b_top, b_bot, b_lft, b_rgt;
  logic [COL_BITS-1:0] b_x;
  logic [PB-1:0]       b_pixel;
  logic [PB-1:0]       win [9];
  logic [PB-1:0]       win_next [9];

  assign item_stall = cfg_busy |
                      ((32'(queue_level) + 32'(b_valid & b_emit)) >=
                       32'(sobel_pkg::FIFO_DEPTH));
  assign accept = item_valid & ~item_stall;

  // Raster position, result decision and border masks of the item at the port.
  always_comb begin
    wrap0 = WB'(column_count) >= width_c;
    x     = wrap0 ? '0 : column_count;
    y     = wrap0 ? row_count + ROW_BITS'(1) : row_count;
    emit  = (y >= ROW_BITS'(2)) || ((y == ROW_BITS'(1)) && (x != '0));
    ex    = (x != '0) ? x - COL_BITS'(1) : COL_BITS'(width_c - WB'(1));
    ey    = (x != '0) ? y - ROW_BITS'(1) : y - ROW_BITS'(2);
    top   = ey != '0;
    bot   = (32'(ey) + 32'd1) < 32'(height_c);
    lft   = ex != '0;
    rgt   = (32'(ex) + 32'd1) < 32'(width_c);
    last  = emit && (32'(emitted_count) >= 32'(total_m1));

    x_inc = (COL_BITS+1)'(x) + (COL_BITS+1)'(1);
    if (32'(x_inc) >= 32'(width_c)) begin
      column_count_next = '0;
      row_count_next    = y + ROW_BITS'(1);
    end else begin
      column_count_next = x_inc[COL_BITS-1:0];
      row_count_next    = y;
    end
    emitted_count_next = emit ? emitted_count + EMIT_BITS'(1) : emitted_count;
    if (last) begin
      column_count_next  = '0;
      row_count_next     = '0;
      emitted_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      emitted_count <= '0;
    end else if (accept) begin
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      emitted_count <= emitted_count_next;
    end
  end

  // Line buffers: read at accept, written back in the cycle after.
  always_ff @(posedge clk) begin
    if (accept) begin
      upper_rd  <= upper_line[x];
      middle_rd <= middle_line[x];
    end
    if (b_valid) begin
      upper_line[b_x]  <= middle_eff;
      middle_line[b_x] <= b_pixel;
    end
  end

  // Forward the write in flight when it hits the address just read.
  always_ff @(posedge clk) begin
    if (accept) begin
      byp_hit    <= b_valid && (b_x == x);
      byp_upper  <= middle_eff;
      byp_middle <= b_pixel;
    end
  end

  assign upper_eff  = byp_hit ? byp_upper  : upper_rd;
  assign middle_eff = byp_hit ? byp_middle : middle_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_x     <= x;
      b_pixel <= (command == sobel_pkg::CMD_PAD) ? '0 : pixel_value;
      b_emit  <= emit;
      b_last  <= last;
      b_top   <= top;
      b_bot   <= bot;
      b_lft   <= lft;
      b_rgt   <= rgt;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]   = win[r*3+1];
      win_next[r*3+1] = win[r*3+2];
    end
    win_next[2] = upper_eff;
    win_next[5] = middle_eff;
    win_next[8] = b_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (b_valid) begin
      win <= win_next;
    end
  end

  always_comb begin
    push.valid    = b_valid & b_emit;
    push.win.last = b_last;
    push.win.tl   = (b_top && b_lft) ? win_next[0] : '0;
    push.win.tc   = b_top            ? win_next[1] : '0;
    push.win.tr   = (b_top && b_rgt) ? win_next[2] : '0;
    push.win.ml   = b_lft            ? win_next[3] : '0;
    push.win.mr   = b_rgt            ? win_next[5] : '0;
    push.win.bl   = (b_bot && b_lft) ? win_next[6] : '0;
    push.win.bc   = b_bot            ? win_next[7] : '0;
    push.win.br   = (b_bot && b_rgt) ? win_next[8] : '0;
  end

endmodule

>>> hw/rtl/sobel_fifo.sv
// Short window queue between the front end and the gradient back end.
module sobel_fifo #(
  localparam int DEPTH    = sobel_pkg::FIFO_DEPTH,
  localparam int PTR_BITS = $clog2(DEPTH),
  localparam int LVL_BITS = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  sobel_pkg::push_t    push,
  output sobel_pkg::window_t  head,
  output logic                head_valid,
  input  logic                pop,
  output logic [LVL_BITS-1:0] level
);

  sobel_pkg::window_t  mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    return (32'(p) == DEPTH - 1) ? '0 : p + PTR_BITS'(1);
  endfunction

  assign head       = mem[rd_ptr];
  assign head_valid = level != '0;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.win;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      level <= level + LVL_BITS'(push.valid) - LVL_BITS'(pop);
    end
  end

endmodule

>>> hw/rtl/sobel_back.sv
// Back end: Sobel sums, squares, threshold compare and output register.
module sobel_back (
  input  logic                              clk,
  input  logic                              rst,
  input  sobel_pkg::window_t                head,
  input  logic                              head_valid,
  output logic                              pop,
  input  logic [sobel_pkg::THRESH_BITS-1:0] edge_threshold,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [sobel_pkg::PIXEL_BITS-1:0]  edge_value,
  output logic                              frame_last
);

  localparam int GB = sobel_pkg::GRAD_BITS;
  localparam int LB = sobel_pkg::THRESH_BITS + 1;

  logic signed [GB-1:0] tl, tc, tr, ml, mr, bl, bc, br, gv, gh;
  logic signed [GB-1:0] s1_gv, s1_gh;
  logic                 s1_valid, s1_last;
  logic signed [2*GB-1:0] prod_v, prod_h;
  logic [sobel_pkg::SQ_BITS-1:0] s2_sq_v, s2_sq_h;
  logic                 s2_valid, s2_last;
  logic [sobel_pkg::MAG_BITS-1:0] mag;
  logic [LB-1:0]        lim;
  logic [2*LB-1:0]      lim_sq;
  logic                 out_en, s2_en, s1_en;

  assign out_en = ~result_valid | ~result_stall;
  assign s2_en  = ~s2_valid | out_en;
  assign s1_en  = ~s1_valid | s2_en;
  assign pop    = head_valid & s1_en;

  always_comb begin
    tl = $signed(GB'(head.tl));
    tc = $signed(GB'(head.tc));
    tr = $signed(GB'(head.tr));
    ml = $signed(GB'(head.ml));
    mr = $signed(GB'(head.mr));
    bl = $signed(GB'(head.bl));
    bc = $signed(GB'(head.bc));
    br = $signed(GB'(head.br));
    gv = (bl + (bc <<< 1) + br) - (tl + (tc <<< 1) + tr);
    gh = (tr + (mr <<< 1) + br) - (tl + (ml <<< 1) + bl);
  end

  assign prod_v = s1_gv * s1_gv;
  assign prod_h = s1_gh * s1_gh;
  assign mag    = sobel_pkg::MAG_BITS'(s2_sq_v) + sobel_pkg::MAG_BITS'(s2_sq_h);
  assign lim    = LB'(edge_threshold) + LB'(1);

  // Threshold square, refreshed every cycle from the register.
  always_ff @(posedge clk) begin
    lim_sq <= lim * lim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= pop;
      end
      if (s2_en) begin
        s2_valid <= s1_valid;
      end
      if (out_en) begin
        result_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_gv   <= gv;
      s1_gh   <= gh;
      s1_last <= head.last;
    end
    if (s2_en) begin
      s2_sq_v <= prod_v[sobel_pkg::SQ_BITS-1:0];
      s2_sq_h <= prod_h[sobel_pkg::SQ_BITS-1:0];
      s2_last <= s1_last;
    end
    if (out_en) begin
      edge_value <= (mag >= sobel_pkg::MAG_BITS'(lim_sq)) ? sobel_pkg::EDGE_ON
                                                          : sobel_pkg::EDGE_OFF;
      frame_last <= s2_last;
    end
  end

endmodule
